### sv/ipsm_pkg.sv
// ----------------------------------------------------------------------------
// ipsm_pkg
// Shared widths, controller states and the command/status bundles that pass
// between the square-and-multiply controller and its datapath.
// ----------------------------------------------------------------------------
package ipsm_pkg;

   localparam int BaseW    = 32;
   localparam int ExpW     = 15;
   localparam int PowW     = 64;
   localparam int HalfW    = PowW / 2;
   localparam int IdxW     = $clog2(ExpW);
   localparam int ReqDataW = ((BaseW + ExpW + 7) / 8) * 8;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_NEXT = 6'b000010,
      ST_PP0  = 6'b000100,
      ST_PP1  = 6'b001000,
      ST_PP2  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   typedef struct packed {
      logic load;
      logic sq_start;
      logic mul_start;
      logic pp0;
      logic pp1;
      logic pp2;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic idx_zero;
      logic exp_bit;
      logic mul_mode;
   } status_type;

endpackage

### sv/ipsm_dp.sv
// ----------------------------------------------------------------------------
// ipsm_dp
// Datapath: operand registers, one shared 32x32 multiplier that builds each
// 64-bit wrapped product from three partial products, and the result register.
// ----------------------------------------------------------------------------
module ipsm_dp
   import ipsm_pkg::*;
(
   input  logic                    clock,
   input  logic [BaseW-1:0]        base,
   input  logic [ExpW-1:0]         exponent,
   input  cmd_type                 cmd,
   output status_type              status,
   output logic [PowW-1:0]         power
);

   logic [PowW-1:0]   base_ff, base_in;
   logic [ExpW-1:0]   exp_ff, exp_in;
   logic [IdxW-1:0]   idx_ff, idx_in;
   logic              mode_ff, mode_in;
   logic [PowW-1:0]   acc_ff, acc_in;
   logic [PowW-1:0]   prod_ff, prod_in;
   logic [PowW-1:0]   power_ff, power_in;

   logic [IdxW-1:0]   top_idx;
   logic [HalfW-1:0]  op_x;
   logic [HalfW-1:0]  op_y;
   logic [PowW-1:0]   op_y_full;
   logic [PowW-1:0]   mul;
   logic [HalfW-1:0]  hi_sum;

   // leading one of the incoming exponent (zero when the exponent is zero)
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < ExpW; i++) begin
         if (exponent[i]) begin
            top_idx = IdxW'(i);
         end
      end
   end

   // partial products: lo*lo, then lo*hi and hi*lo into the upper half
   assign op_y_full = mode_ff ? base_ff : acc_ff;
   assign op_x      = cmd.pp2 ? acc_ff[PowW-1:HalfW] : acc_ff[HalfW-1:0];
   assign op_y      = cmd.pp1 ? op_y_full[PowW-1:HalfW] : op_y_full[HalfW-1:0];
   assign mul       = {{HalfW{1'b0}}, op_x} * {{HalfW{1'b0}}, op_y};
   assign hi_sum    = prod_ff[PowW-1:HalfW] + mul[HalfW-1:0];

   always_comb begin
      base_in  = base_ff;
      exp_in   = exp_ff;
      idx_in   = idx_ff;
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      power_in = power_ff;
      if (cmd.load) begin
         base_in = {{(PowW-BaseW){base[BaseW-1]}}, base};
         exp_in  = exponent;
         idx_in  = top_idx;
         acc_in  = (exponent == '0) ? PowW'(1) : {{(PowW-BaseW){base[BaseW-1]}}, base};
      end
      if (cmd.sq_start) begin
         idx_in  = idx_ff - IdxW'(1);
         mode_in = 1'b0;
      end
      if (cmd.mul_start) begin
         mode_in = 1'b1;
      end
      if (cmd.pp0) begin
         prod_in = mul;
      end
      if (cmd.pp1) begin
         prod_in = {hi_sum, prod_ff[HalfW-1:0]};
      end
      if (cmd.pp2) begin
         acc_in = {hi_sum, prod_ff[HalfW-1:0]};
      end
      if (cmd.out_load) begin
         power_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      exp_ff   <= exp_in;
      idx_ff   <= idx_in;
      mode_ff  <= mode_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      power_ff <= power_in;
   end

   assign status.idx_zero = (idx_ff == '0);
   assign status.exp_bit  = exp_ff[idx_ff];
   assign status.mul_mode = mode_ff;
   assign power           = power_ff;

endmodule

### sv/ipsm_ctrl.sv
// ----------------------------------------------------------------------------
// ipsm_ctrl
// Controller: walks the exponent bits below the leading one, sequences the
// three partial products of each square or multiply, owns the handshakes.
// ----------------------------------------------------------------------------
module ipsm_ctrl
   import ipsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  status_type  status,
   output cmd_type     cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (status.idx_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.sq_start = 1'b1;
               state_in     = ST_PP0;
            end
         end
         ST_PP0: begin
            cmd.pp0  = 1'b1;
            state_in = ST_PP1;
         end
         ST_PP1: begin
            cmd.pp1  = 1'b1;
            state_in = ST_PP2;
         end
         ST_PP2: begin
            cmd.pp2 = 1'b1;
            // after a square, multiply by the base when this bit is set
            if (!status.mul_mode && status.exp_bit) begin
               cmd.mul_start = 1'b1;
               state_in      = ST_PP0;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

### sv/integer_power_square_multiply.sv
// ----------------------------------------------------------------------------
// integer_power_square_multiply
// Raises a signed 32-bit base to a 15-bit unsigned exponent, result wrapped
// to a signed 64-bit value, by left-to-right square-and-multiply.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one request carries base and exponent. It is
//   taken when req_tvalid and req_tready are both high; req_tready is high
//   only while no request is in progress, so one request is worked at a time.
//   Response channel (rsp_*): one response per request carrying the power.
//   It holds in an output register until rsp_tready takes it.
// Sequence:
//   For each exponent bit below the leading one the controller steps the
//   bit index, squares, and multiplies by the base when the bit is set.
//   Every square or multiply runs as three partial products on the single
//   shared 32x32 multiplier (low*low, low*high, high*low). The result then
//   goes to the output register, and the next request is taken once the
//   controller is back in idle.
// Reset: synchronous, returns the controller to idle and drops rsp_tvalid.
// Stall: a finished result waits in the output register; while it waits a
//   new request is still taken and worked, and only its own hand-off holds.
// ----------------------------------------------------------------------------
module integer_power_square_multiply
   import ipsm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [ReqDataW-1:0]  req_tdata,   // [31:0] base, [46:32] exponent, [47] zero
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [PowW-1:0]      rsp_tdata    // [63:0] power
);

   cmd_type    cmd;
   status_type status;

   // sequence the square and multiply steps
   ipsm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // hold operands, run the shared multiplier, hold the result
   ipsm_dp u_dp (
      .clock    (clock),
      .base     (req_tdata[BaseW-1:0]),
      .exponent (req_tdata[BaseW+ExpW-1:BaseW]),
      .cmd      (cmd),
      .status   (status),
      .power    (rsp_tdata)
   );

endmodule

### sv/ipsm_checker.sv
// ----------------------------------------------------------------------------
// ipsm_checker
// Port-level checks for integer_power_square_multiply, bound to the top level.
// ----------------------------------------------------------------------------
module ipsm_checker
   import ipsm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [ReqDataW-1:0]  req_tdata,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [PowW-1:0]      rsp_tdata
);

   // reset drops any pending response
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds its value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response dropped or changed");

   // one request in progress at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   // zero exponent, no multiply: a free output gives 1 after ST_NEXT, ST_DONE
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tdata[BaseW+ExpW-1:BaseW] == '0) &&
       !rsp_tvalid) ##2 1 |=> (rsp_tvalid && (rsp_tdata == PowW'(1))))
      else $error("zero exponent did not give one");

endmodule

bind integer_power_square_multiply ipsm_checker u_ipsm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### dv/integer_power_square_multiply_tb.sv
// ----------------------------------------------------------------------------
// integer_power_square_multiply_tb
// Self-checking bench for the square-and-multiply power block. A directed
// burst hits the corner values of base and exponent, then about 1500 random
// requests follow in chunks with random sender gaps and receiver stalls.
// Every response is compared in order against a local power predictor.
// ----------------------------------------------------------------------------
module integer_power_square_multiply_tb
   import ipsm_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ChunkCount = 15;
   localparam int ChunkSize  = 100;
   localparam int MaxGap     = 10;
   // Leave room after the last request for trailing output.
   localparam int DrainCycles = 150;
   // The limit lies well above the slowest legal run.
   localparam int CycleLimit  = 1_000_000;

   typedef struct packed {
      logic [ExpW-1:0]         exponent;
      logic signed [BaseW-1:0] base;
   } power_request_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;   // [31:0] base, [46:32] exponent, [47] zero
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [PowW-1:0]     rsp_tdata;        // [63:0] power

   power_request_type pending_requests[$];
   logic [PowW-1:0]   expected_powers[$];

   bit sender_idle_on   = 1'b0;
   bit receiver_idle_on = 1'b0;
   int failures         = 0;
   int accepted_count   = 0;
   int received_count   = 0;
   int zero_exp_count   = 0;
   int wide_exp_count   = 0;
   int cycle_count      = 0;

   integer_power_square_multiply u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Power modulo 2^64: walk the exponent from the top bit down, square once
   // the leading one has been seen and fold in the base on every set bit.
   function automatic logic [PowW-1:0] raise_power(input logic signed [BaseW-1:0] base,
                                                   input logic [ExpW-1:0] exponent);
      logic [PowW-1:0] wide_base;
      logic [PowW-1:0] running;
      bit              seen_one;
      wide_base = {{(PowW-BaseW){base[BaseW-1]}}, base};
      running   = 64'd1;
      seen_one  = 1'b0;
      for (int i = ExpW - 1; i >= 0; i--) begin
         if (seen_one) begin
            running = running * running;
         end
         if (exponent[i]) begin
            running  = seen_one ? running * wide_base : wide_base;
            seen_one = 1'b1;
         end
      end
      return running;
   endfunction

   // Queue one request; call only away from the rising edge.
   task automatic queue_request(input logic signed [BaseW-1:0] base,
                                input logic [ExpW-1:0] exponent);
      power_request_type item;
      item.base     = base;
      item.exponent = exponent;
      pending_requests.push_back(item);
   endtask

   function automatic logic signed [BaseW-1:0] pick_base();
      int kind;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2, 3, 4: begin
            return $urandom;
         end
         5, 6, 7: begin
            return $signed($urandom_range(0, 40)) - 20;
         end
         8: begin
            return $urandom | 32'd1;
         end
         default: begin
            case ($urandom_range(0, 4))
               0:       return 32'sd0;
               1:       return 32'sd1;
               2:       return -32'sd1;
               3:       return 32'h8000_0000;
               default: return 32'h7FFF_FFFF;
            endcase
         end
      endcase
   endfunction

   function automatic logic [ExpW-1:0] pick_exponent();
      int kind;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2, 3: begin
            return ExpW'($urandom_range(0, 32767));
         end
         4, 5, 6: begin
            return ExpW'($urandom_range(0, 70));
         end
         7: begin
            return 15'h7FFF ^ (15'd1 << $urandom_range(0, ExpW - 1));
         end
         8: begin
            return 15'd1 << $urandom_range(0, ExpW - 1);
         end
         default: begin
            return ExpW'($urandom_range(0, 3));
         end
      endcase
   endfunction

   // Driver: present the head of the pending queue, hold it until taken,
   // then idle for a drawn number of cycles before the next request.
   int send_gap = 0;
   always @(posedge clock) begin
      power_request_type head;
      bit                taken;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap   = 0;
      end else begin
         taken = req_tvalid && req_tready;
         if (taken) begin
            head = pending_requests.pop_front();
            expected_powers.push_back(raise_power(head.base, head.exponent));
            accepted_count++;
            if (head.exponent == '0) begin
               zero_exp_count++;
            end
            if (head.exponent[ExpW-1]) begin
               wide_exp_count++;
            end
            send_gap = sender_idle_on ? $urandom_range(0, MaxGap) : 0;
         end
         if (req_tvalid && !taken) begin
            // hold the offered request until the block takes it
         end else if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            head = pending_requests[0];
            req_tvalid <= 1'b1;
            req_tdata  <= {{(ReqDataW-BaseW-ExpW){1'b0}}, head.exponent, head.base};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: take each response, check it against the oldest prediction,
   // then stall for a drawn number of cycles.
   int stall_left = 0;
   always @(posedge clock) begin
      logic [PowW-1:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            received_count++;
            if (expected_powers.size() == 0) begin
               $error("power: response with no request outstanding, actual %0d",
                      $signed(rsp_tdata));
               failures++;
            end else begin
               want = expected_powers.pop_front();
               if (rsp_tdata !== want) begin
                  $error("power mismatch: expected %0d, actual %0d",
                         $signed(want), $signed(rsp_tdata));
                  failures++;
               end
            end
            stall_left = receiver_idle_on ? $urandom_range(0, MaxGap) : 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d requests still expected",
                  cycle_count, expected_powers.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      // Hold reset from time zero, then release it at a rising edge.
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed corners, sent back to back.
      queue_request(32'sd0, 15'd0);               // zero to the zero
      queue_request(32'h8000_0000, 15'd0);        // most negative base, zero exponent
      queue_request(32'sd5, 15'd1);               // exponent of one
      queue_request(32'h8000_0000, 15'd1);
      queue_request(32'h7FFF_FFFF, 15'd1);
      queue_request(32'sd0, 15'd1);
      queue_request(-32'sd1, 15'h7FFF);           // odd power of minus one
      queue_request(-32'sd1, 15'h7FFE);           // even power of minus one
      queue_request(32'sd2, 15'd63);              // lands on the sign bit
      queue_request(32'sd2, 15'd64);              // wraps to zero
      queue_request(-32'sd2, 15'd63);
      queue_request(32'sd3, 15'd40);              // wraps without a flag
      queue_request(32'h7FFF_FFFF, 15'h7FFF);
      queue_request(32'h8000_0000, 15'h7FFF);
      queue_request(32'sd0, 15'h7FFF);
      queue_request(32'sd1, 15'h7FFF);
      queue_request(-32'sd3, 15'h5555);           // alternating exponent bits
      queue_request(32'sd7, 15'h2AAA);
      queue_request(32'sd12345, 15'h4000);        // squares only
      queue_request(-32'sd7, 15'h7FFF);           // every bit set
      while (pending_requests.size() != 0) @(negedge clock);

      // Random chunks, each with its own idling pattern; some run flat out.
      for (int c = 0; c < ChunkCount; c++) begin
         sender_idle_on   = ($urandom_range(0, 3) != 0);
         receiver_idle_on = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < ChunkSize; n++) begin
            queue_request(pick_base(), pick_exponent());
         end
         while (pending_requests.size() != 0) @(negedge clock);
      end

      // Drain: wait for the last response, then watch for strays.
      while (req_tvalid || expected_powers.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);

      $display("covered %0d requests, %0d responses checked", accepted_count,
               received_count);
      $display("  %0d zero exponents, %0d with the top exponent bit set", zero_exp_count,
               wide_exp_count);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### integer_power_square_multiply.f
sv/ipsm_pkg.sv
sv/ipsm_dp.sv
sv/ipsm_ctrl.sv
sv/integer_power_square_multiply.sv
sv/ipsm_checker.sv
dv/integer_power_square_multiply_tb.sv
